// ----- src/line_rasterizer_defines.svh -----
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line rasterizer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line rasterizer check failed");

`endif

// ----- src/lr_pkg.sv -----
// Shared types and constants of the line rasterizer.
`default_nettype none
package lr_pkg;

	localparam int unsigned SCREEN_WIDTH  = 160;
	localparam int unsigned SCREEN_HEIGHT = 128;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [7:0]  start_x;
		logic [7:0]  start_y;
		logic [7:0]  end_x;
		logic [7:0]  end_y;
		logic [15:0] colour;
	} lr_cmd_t;

	typedef struct packed {
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [15:0] pixel_colour;
		logic        on_screen;
		logic        last_pixel;
	} lr_pix_t;

	typedef struct packed {
		logic [7:0]        cur_col;
		logic [7:0]        cur_row;
		logic [7:0]        goal_col;
		logic [7:0]        goal_row;
		logic [8:0]        delta_col;
		logic [8:0]        delta_row;
		logic signed [9:0] error_term;
		logic              step_col_negative;
		logic              step_row_negative;
		logic [15:0]       line_colour;
		logic              busy;
	} lr_state_t;

endpackage
`default_nettype wire

// ----- src/lr_ifs.sv -----
// Valid/ready channel interfaces for line commands and pixels.
`default_nettype none
interface lr_cmd_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  start_x;
	logic [7:0]  start_y;
	logic [7:0]  end_x;
	logic [7:0]  end_y;
	logic [15:0] colour;

	modport source (output valid, action, start_x, start_y, end_x, end_y, colour,
		input ready);
	modport sink (input valid, action, start_x, start_y, end_x, end_y, colour,
		output ready);
endinterface

interface lr_pix_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [15:0] pixel_colour;
	logic        on_screen;
	logic        last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_colour, on_screen, last_pixel,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_colour, on_screen, last_pixel,
		output ready);
endinterface
`default_nettype wire

// ----- src/lr_step.sv -----
// One Bresenham step: next line state and emitted pixel for one command item.
`default_nettype none
module lr_step import lr_pkg::*; (
	input  wire lr_state_t st,
	input  wire lr_cmd_t   cmd,
	output lr_state_t      st_next,
	output lr_pix_t        pix,
	output logic           emit
);
	logic              neg_col;
	logic              neg_row;
	logic [7:0]        abs_col;
	logic [7:0]        abs_row;
	logic              at_goal;
	logic signed [11:0] e2;
	logic signed [11:0] dc_w;
	logic signed [11:0] dr_w;
	logic              move_col;
	logic              move_row;
	logic signed [11:0] err_w;

	always_comb begin
		neg_col = cmd.end_x < cmd.start_x;
		neg_row = cmd.end_y < cmd.start_y;
		abs_col = neg_col ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
		abs_row = neg_row ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;

		at_goal = (st.cur_col == st.goal_col) && (st.cur_row == st.goal_row);
		e2 = {{1{st.error_term[9]}}, st.error_term, 1'b0};
		dc_w = signed'({3'b000, st.delta_col});
		dr_w = signed'({3'b000, st.delta_row});
		move_col = e2 > -dr_w;
		move_row = e2 < dc_w;
		err_w = {{2{st.error_term[9]}}, st.error_term};
		if (move_col)
			err_w = err_w - dr_w;
		if (move_row)
			err_w = err_w + dc_w;

		pix.pixel_x = st.cur_col;
		pix.pixel_y = st.cur_row;
		pix.pixel_colour = st.line_colour;
		pix.on_screen = ({1'b0, st.cur_col} < 9'(SCREEN_WIDTH))
			&& ({1'b0, st.cur_row} < 9'(SCREEN_HEIGHT));
		pix.last_pixel = at_goal;

		st_next = st;
		emit = 1'b0;
		if (cmd.action == ACT_START) begin
			st_next.cur_col = cmd.start_x;
			st_next.cur_row = cmd.start_y;
			st_next.goal_col = cmd.end_x;
			st_next.goal_row = cmd.end_y;
			st_next.step_col_negative = neg_col;
			st_next.step_row_negative = neg_row;
			st_next.delta_col = {1'b0, abs_col};
			st_next.delta_row = {1'b0, abs_row};
			st_next.error_term = signed'({2'b00, abs_col}) - signed'({2'b00, abs_row});
			st_next.line_colour = cmd.colour;
			st_next.busy = 1'b1;
		end else if (st.busy) begin
			emit = 1'b1;
			if (at_goal) begin
				st_next.busy = 1'b0;
			end else begin
				st_next.error_term = err_w[9:0];
				if (move_col)
					st_next.cur_col = st.step_col_negative ? st.cur_col - 8'd1
						: st.cur_col + 8'd1;
				if (move_row)
					st_next.cur_row = st.step_row_negative ? st.cur_row - 8'd1
						: st.cur_row + 8'd1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/line_rasterizer.sv -----
// Line rasterizer top level: command channel in, pixel stream out.
// Walks a straight line between two 8-bit endpoints and hands out one pixel
// per advance item, from the first endpoint to the second, both included.
// A start item (action 0) loads endpoints and colour and produces nothing;
// each advance item (action 1) while a line is active produces one pixel
// with its colour, an on-screen flag (inside 160 x 128) and a last-pixel
// flag; after the last pixel the block goes idle and further advances are
// dropped without a result. A start during a line abandons it. The
// Bresenham step is one add/compare pass from the state registers into
// the pixel output register, so a new item is taken every cycle as long
// as the output register is free or being drained in the same cycle.
// Pixels off the screen are still emitted, never clamped.
`default_nettype none
`include "line_rasterizer_defines.svh"
module line_rasterizer import lr_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	lr_cmd_if.sink   cmd,
	lr_pix_if.source pix
);
	lr_state_t st_q;
	lr_state_t st_next;
	lr_cmd_t   cmd_item;
	lr_pix_t   pix_calc;
	lr_pix_t   pix_q;
	logic      pix_valid_q;
	logic      emit;
	logic      cmd_fire;

	assign cmd_item = '{action: cmd.action, start_x: cmd.start_x, start_y: cmd.start_y,
		end_x: cmd.end_x, end_y: cmd.end_y, colour: cmd.colour};

	// Output register frees up when empty or when its pixel is taken now.
	assign cmd.ready = !pix_valid_q || pix.ready;
	assign cmd_fire = cmd.valid && cmd.ready;

	lr_step u_step (
		.st      (st_q),
		.cmd     (cmd_item),
		.st_next (st_next),
		.pix     (pix_calc),
		.emit    (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (cmd_fire)
				st_q <= st_next;
			if (cmd_fire && emit)
				pix_valid_q <= 1'b1;
			else if (pix.ready)
				pix_valid_q <= 1'b0;
		end
	end

	// Pixel payload, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd_fire && emit)
			pix_q <= pix_calc;
	end

	assign pix.valid = pix_valid_q;
	assign pix.pixel_x = pix_q.pixel_x;
	assign pix.pixel_y = pix_q.pixel_y;
	assign pix.pixel_colour = pix_q.pixel_colour;
	assign pix.on_screen = pix_q.on_screen;
	assign pix.last_pixel = pix_q.last_pixel;

	`LR_ASSERT_NEXT(a_start_busy, clk, arst_n, cmd_fire && cmd.action == ACT_START,
		st_q.busy)
	`LR_ASSERT_NEXT(a_adv_emits, clk, arst_n,
		cmd_fire && cmd.action == ACT_ADVANCE && st_q.busy, pix.valid)
	`LR_ASSERT_NEXT(a_last_idles, clk, arst_n,
		cmd_fire && cmd.action == ACT_ADVANCE && st_q.busy
		&& st_q.cur_col == st_q.goal_col && st_q.cur_row == st_q.goal_row,
		!st_q.busy && pix.last_pixel)
	`LR_ASSERT_NOW(a_idle_silent, clk, arst_n,
		cmd_fire && cmd.action == ACT_ADVANCE && !st_q.busy, !emit)
endmodule
`default_nettype wire

// ----- bench/line_rasterizer_checker.sv -----
// Scoreboard for the line rasterizer: predicts every pixel and checks the pixel stream.
module line_rasterizer_checker import lr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	lr_cmd_if     cmd,
	lr_pix_if     pix,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 200;

	// Shadow of the walker state
	logic [7:0]        col, row, goal_c, goal_r;
	logic [8:0]        span_c, span_r;
	logic signed [9:0] err;
	logic              neg_c, neg_r;
	logic [15:0]       ink;
	logic              drawing;

	lr_pix_t pixels_due[$];
	int      errors;

	task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// One command item through the Bresenham walker
	task automatic trace_step(input lr_cmd_t c);
		lr_pix_t p;
		int      e, e2, dc, dr;
		if (c.action == ACT_START) begin
			col     = c.start_x;
			row     = c.start_y;
			goal_c  = c.end_x;
			goal_r  = c.end_y;
			neg_c   = c.end_x < c.start_x;
			neg_r   = c.end_y < c.start_y;
			span_c  = neg_c ? c.start_x - c.end_x : c.end_x - c.start_x;
			span_r  = neg_r ? c.start_y - c.end_y : c.end_y - c.start_y;
			err     = 10'(int'(span_c) - int'(span_r));
			ink     = c.colour;
			drawing = 1'b1;
		end else if (drawing) begin
			p.pixel_x      = col;
			p.pixel_y      = row;
			p.pixel_colour = ink;
			p.on_screen    = (int'(col) < SCREEN_WIDTH) && (int'(row) < SCREEN_HEIGHT);
			p.last_pixel   = (col == goal_c) && (row == goal_r);
			pixels_due.push_back(p);
			if (p.last_pixel) begin
				drawing = 1'b0;
			end else begin
				e  = int'(err);
				e2 = e * 2;
				dc = int'(span_c);
				dr = int'(span_r);
				if (e2 > -dr) begin
					e   = e - dr;
					col = neg_c ? col - 8'd1 : col + 8'd1;
				end
				if (e2 < dc) begin
					e   = e + dc;
					row = neg_r ? row - 8'd1 : row + 8'd1;
				end
				err = 10'(e);
			end
		end
	endtask

	task automatic check_pixel();
		lr_pix_t got, want;
		got = {pix.pixel_x, pix.pixel_y, pix.pixel_colour, pix.on_screen, pix.last_pixel};
		if (pixels_due.size() == 0) begin
			errors++;
			if (errors <= PRINT_CAP)
				$display("%0t: unexpected pixel, expected none, got (%0d,%0d)",
					$realtime, got.pixel_x, got.pixel_y);
		end else begin
			want = pixels_due.pop_front();
			if (got.pixel_x !== want.pixel_x)
				flag("pixel_x", want.pixel_x, got.pixel_x);
			if (got.pixel_y !== want.pixel_y)
				flag("pixel_y", want.pixel_y, got.pixel_y);
			if (got.pixel_colour !== want.pixel_colour)
				flag("pixel_colour", want.pixel_colour, got.pixel_colour);
			if (got.on_screen !== want.on_screen)
				flag("on_screen", want.on_screen, got.on_screen);
			if (got.last_pixel !== want.last_pixel)
				flag("last_pixel", want.last_pixel, got.last_pixel);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col        = '0;
			row        = '0;
			goal_c     = '0;
			goal_r     = '0;
			span_c     = '0;
			span_r     = '0;
			err        = '0;
			neg_c      = 1'b0;
			neg_r      = 1'b0;
			ink        = '0;
			drawing    = 1'b0;
			errors     = 0;
			pixels_due.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// a pixel leaving now was computed from an earlier command
			if (pix.valid && pix.ready)
				check_pixel();
			if (cmd.valid && cmd.ready)
				trace_step({cmd.action, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
					cmd.colour});
			fail_count <= errors;
			pending    <= pixels_due.size();
		end
	end
endmodule

// ----- bench/line_rasterizer_tb.sv -----
// Testbench top for the line rasterizer: clock, reset, command stimulus and verdict.
module line_rasterizer_tb import lr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT       = 1_000_000; // cycles before the run is called hung
	localparam int RAND_ITEMS  = 800;       // random command items to offer
	localparam int SQUEEZE_LEN = 400;       // long receiver hold-off, in cycles
	localparam int DRAIN       = 16;        // settle cycles after the last pixel

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;

	// squeeze: stimulus asks the pixel side for one long hold-off
	logic squeeze;
	logic squeezed;
	int   send_calm;

	lr_cmd_if cmd_ch();
	lr_pix_if pix_ch();

	line_rasterizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pix    (pix_ch)
	);

	line_rasterizer_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.pix        (pix_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: anything that hangs ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Offer one command item and hold it until the block takes it.
	// valid is only lowered when a gap follows, so back-to-back items never
	// see valid dropped and raised in the same step.
	task automatic offer(input lr_cmd_t c);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 39) == 0)
				send_calm = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.action  <= c.action;
		cmd_ch.start_x <= c.start_x;
		cmd_ch.start_y <= c.start_y;
		cmd_ch.end_x   <= c.end_x;
		cmd_ch.end_y   <= c.end_y;
		cmd_ch.colour  <= c.colour;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic start_line(input logic [7:0] sx, input logic [7:0] sy,
		input logic [7:0] ex, input logic [7:0] ey, input logic [15:0] colour);
		offer({ACT_START, sx, sy, ex, ey, colour});
	endtask

	// Advance items carry random junk in the unused fields.
	task automatic advance(input int n);
		repeat (n)
			offer({ACT_ADVANCE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				16'($urandom)});
	endtask

	// Endpoint near a base, clipped to the 8-bit range (so edges get hit).
	function automatic logic [7:0] nudge(input logic [7:0] base);
		int v;
		v = int'(base) + int'($urandom_range(0, 24)) - 12;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	// Pixel side: random stalls with calm stretches, plus one long squeeze
	// while the sender keeps pushing, so the block backs up into cmd.ready.
	initial begin
		int stall_left;
		int calm_left;
		pix_ch.ready = 1'b0;
		stall_left   = 0;
		calm_left    = 0;
		squeezed     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				pix_ch.ready <= 1'b0;
				repeat (SQUEEZE_LEN) @(posedge clk);
			end else if (stall_left > 0) begin
				pix_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				pix_ch.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 59) == 0)
					calm_left = $urandom_range(30, 150);
				else if ($urandom_range(0, 4) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Main stimulus
	initial begin
		logic [7:0] sx, sy, ex, ey;
		int         dx, dy, span, n, counted, pick;
		lr_cmd_t    junk;

		arst_n         = 1'b0;
		squeeze        = 1'b0;
		send_calm      = 0;
		cycles         = 0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.action  = ACT_ADVANCE;
		cmd_ch.start_x = '0;
		cmd_ch.start_y = '0;
		cmd_ch.end_x   = '0;
		cmd_ch.end_y   = '0;
		cmd_ch.colour  = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// advance with no line loaded: dropped
		advance(1);
		// single-point line, then one more advance after it went idle
		start_line(8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
		advance(2);
		// reversed horizontal, fully off screen, starts on the 255 corner
		start_line(8'd255, 8'd255, 8'd250, 8'd255, 16'hFFFF);
		advance(6);
		// reversed vertical crossing the bottom screen edge
		start_line(8'd159, 8'd129, 8'd159, 8'd125, 16'h07E0);
		advance(5);
		// long diagonal from one corner to the other, cut short by a new start
		start_line(8'd0, 8'd255, 8'd255, 8'd0, 16'hA5A5);
		advance(3);
		start_line(8'd10, 8'd20, 8'd13, 8'd18, 16'h5A5A);
		advance(4);

		// --- random ---
		squeeze = 1'b1;
		counted = 0;
		while (counted < RAND_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: any action with any payload
				junk = lr_cmd_t'({$urandom, $urandom});
				offer(junk);
				if (junk.action == ACT_START)
					counted++;
			end else begin
				sx = 8'($urandom);
				sy = 8'($urandom);
				if ($urandom_range(0, 14) == 0) begin
					// rare long line anywhere on the grid
					ex = 8'($urandom);
					ey = 8'($urandom);
				end else begin
					ex = nudge(sx);
					ey = nudge(sy);
				end
				dx   = (ex > sx) ? ex - sx : sx - ex;
				dy   = (ey > sy) ? ey - sy : sy - ey;
				span = ((dx > dy) ? dx : dy) + 1;
				start_line(sx, sy, ex, ey, 16'($urandom));
				pick = $urandom_range(0, 7);
				// sometimes abandon partway, sometimes overrun into idle
				n = (pick == 0) ? $urandom_range(1, span) : span;
				advance(n);
				counted += n + 1;
				if (pick == 1)
					advance($urandom_range(1, 3));
			end
		end

		// --- drain ---
		cmd_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- line_rasterizer.f -----
+incdir+src
src/lr_pkg.sv
src/lr_ifs.sv
src/lr_step.sv
src/line_rasterizer.sv
bench/line_rasterizer_checker.sv
bench/line_rasterizer_tb.sv
